// File: src/assert_macros.svh
// Assertion helpers for the RTL; included by smx_fifo.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge out of reset.
`define SMX_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define SMX_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/smx_pkg.sv
package smx_pkg;
    localparam int ROW_LEN = 64;
    localparam int IW = (ROW_LEN > 1) ? $clog2(ROW_LEN) : 1;
    localparam int CW = $clog2(ROW_LEN + 1);
    localparam int SW = $clog2(ROW_LEN) + 17;
    localparam int DW = 34;
    localparam int QD = 4;
    localparam int QW = $clog2(QD);

    typedef struct packed {
        logic [15:0]        score;
        logic               store;
        logic               last;
        logic [IW-1:0]      idx;
        logic signed [15:0] maxv;
        logic               ovf;
        logic [CW-1:0]      cnt;
    } t_entry;

    // round(65536 * 2^(-k/16))
    function automatic logic [16:0] pow2_q16(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction
endpackage

// File: src/smx_front.sv
module smx_front import smx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_full,
    output logic        o_push,
    output t_entry      o_entry
);
    logic [CW-1:0]      r_cnt, n_cnt;
    logic signed [15:0] r_max, n_max;
    logic               r_ovf, n_ovf;
    logic               w_store;
    logic signed [15:0] w_s;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;
    assign w_s        = $signed(i_s_tdata);
    assign w_store    = r_cnt < CW'(ROW_LEN);

    always_comb begin
        n_max = (w_store && (w_s > r_max)) ? w_s : r_max;
        n_ovf = r_ovf | !w_store;
        n_cnt = w_store ? r_cnt + CW'(1) : r_cnt;
        o_entry.score = i_s_tdata;
        o_entry.store = w_store;
        o_entry.last  = i_s_tlast;
        o_entry.idx   = r_cnt[IW-1:0];
        o_entry.maxv  = n_max;
        o_entry.ovf   = n_ovf;
        o_entry.cnt   = n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_max <= 16'sh8000;
            r_ovf <= 1'b0;
        end else if (o_push) begin
            if (i_s_tlast) begin
                r_cnt <= '0;
                r_max <= 16'sh8000;
                r_ovf <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_max <= n_max;
                r_ovf <= n_ovf;
            end
        end
    end
endmodule

// File: src/smx_fifo.sv
`include "assert_macros.svh"
module smx_fifo import smx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_entry
);
    t_entry        r_mem [QD];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;

    assign o_full  = r_cnt == (QW+1)'(QD);
    assign o_empty = r_cnt == '0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + QW'(1);
            if (i_pop)  r_rp <= r_rp + QW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `SMX_ALWAYS(a_no_push_full, !(i_push && o_full))
    `SMX_ALWAYS(a_no_pop_empty, !(i_pop && o_empty))
    `SMX_NEXT(a_fill_up, i_push && !i_pop, r_cnt == $past(r_cnt) + (QW+1)'(1))
endmodule

// File: src/smx_back.sv
module smx_back import smx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_entry      i_entry,
    output logic        o_pop,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,
    output logic        o_m_tlast,
    output logic        o_m_tuser
);
    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EXP1 = 3'd2;
    localparam logic [2:0] ST_EXP2 = 3'd3;
    localparam logic [2:0] ST_EXP3 = 3'd4;
    localparam logic [2:0] ST_POST = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [15:0]        r_mem [ROW_LEN];
    logic [2:0]         r_state;
    logic [IW-1:0]      r_idx;
    logic [CW-1:0]      r_cnt;
    logic signed [15:0] r_max;
    logic               r_ovf, r_emit;
    logic [15:0]        r_rd;
    logic [32:0]        r_t;
    logic [8:0]         r_n;
    logic [16:0]        r_hi;
    logic [32:0]        r_prod;
    logic [16:0]        r_e;
    logic [SW-1:0]      r_sum, r_rem;
    logic [DW-1:0]      r_dv;
    logic [5:0]         r_dc;
    logic [15:0]        r_prob;

    logic [15:0]   w_m;
    logic [32:0]   w_t;
    logic [16:0]   w_hi, w_lo, w_diff;
    logic [16:0]   w_p, w_e;
    logic [17:0]   w_rnd;
    logic [4:0]    w_sh;
    logic [SW:0]   w_trial;
    logic          w_ge;
    logic          w_lastel;

    assign o_pop      = (r_state == ST_LOAD) && !i_empty;
    assign w_lastel   = CW'(r_idx) == r_cnt - CW'(1);
    assign o_m_tvalid = r_state == ST_OUT;
    assign o_m_tdata  = r_prob;
    assign o_m_tlast  = w_lastel;
    assign o_m_tuser  = r_ovf;

    always_comb begin
        w_m    = 16'(r_max - $signed(r_rd));
        w_t    = 33'(w_m) * 33'd94548;
        w_hi   = pow2_q16({1'b0, r_t[23:20]});
        w_lo   = pow2_q16(5'({1'b0, r_t[23:20]}) + 5'd1);
        w_diff = w_hi - w_lo;
        w_p    = r_hi - 17'(r_prod >> 20);
        w_sh   = r_n[4:0];
        w_rnd  = 18'(w_p) + (18'd1 << (w_sh - 5'd1));
        if (r_n == 9'd0)       w_e = w_p;
        else if (r_n >= 9'd18) w_e = '0;
        else                   w_e = 17'(w_rnd >> w_sh);
        w_trial = {r_rem, r_dv[DW-1]};
        w_ge    = w_trial >= {1'b0, r_sum};
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_entry.store) r_mem[i_entry.idx] <= i_entry.score;
        if (r_state == ST_RD) r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        r_t    <= w_t;
        r_n    <= r_t[32:24];
        r_hi   <= w_hi;
        r_prod <= 33'(w_diff) * 33'(r_t[19:0]) + 33'd524288;
        if (r_state == ST_EXP3) r_e <= w_e;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_idx   <= '0;
            r_cnt   <= '0;
            r_max   <= 16'sh8000;
            r_ovf   <= 1'b0;
            r_emit  <= 1'b0;
            r_sum   <= '0;
            r_dc    <= '0;
        end else begin
            case (r_state)
                ST_LOAD: begin
                    if (o_pop && i_entry.last) begin
                        r_max   <= i_entry.maxv;
                        r_cnt   <= i_entry.cnt;
                        r_ovf   <= i_entry.ovf;
                        r_idx   <= '0;
                        r_emit  <= 1'b0;
                        r_sum   <= '0;
                        r_state <= ST_RD;
                    end
                end
                ST_RD:   r_state <= ST_EXP1;
                ST_EXP1: r_state <= ST_EXP2;
                ST_EXP2: r_state <= ST_EXP3;
                ST_EXP3: r_state <= ST_POST;
                ST_POST: begin
                    if (!r_emit) begin
                        r_sum <= r_sum + SW'(r_e);
                        if (w_lastel) begin
                            r_idx  <= '0;
                            r_emit <= 1'b1;
                        end else begin
                            r_idx <= r_idx + IW'(1);
                        end
                        r_state <= ST_RD;
                    end else begin
                        r_dv    <= (DW'(r_e) << 16) + DW'(r_sum >> 1);
                        r_rem   <= '0;
                        r_dc    <= '0;
                        r_state <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    r_rem <= w_ge ? SW'(w_trial - {1'b0, r_sum}) : SW'(w_trial);
                    r_dv  <= {r_dv[DW-2:0], w_ge};
                    r_dc  <= r_dc + 6'd1;
                    if (r_dc == 6'(DW - 1)) r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (i_m_tready) begin
                        if (w_lastel) begin
                            r_state <= ST_LOAD;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= ST_RD;
                        end
                    end
                end
                default: r_state <= ST_LOAD;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV && r_dc == 6'(DW - 1)) begin
            r_prob <= (|r_dv[DW-2:15]) ? 16'hFFFF : {r_dv[14:0], w_ge};
        end
    end
endmodule

// File: src/softmax_row_unit.sv
// After the last element of a row, the back end first sums the exponentials of the
// row, then computes each probability in turn through the exp pipeline, the
// radix-2 divider and the transfer. Elements load one per cycle while the 4-deep
// queue has room.
// The row buffer is written from the queue; the back end holds it per row.
// Reset: i_rst_n synchronous, active low; clears counters, queue and state.
module softmax_row_unit import smx_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [15:0] score
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] probability
    output logic        o_m_tlast,
    output logic        o_m_tuser    // [0] row_overflow
);
    t_entry w_push_e, w_pop_e;
    logic   w_push, w_pop, w_full, w_empty;

    smx_front u_front (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata, .i_s_tlast,
        .i_full(w_full), .o_push(w_push), .o_entry(w_push_e)
    );

    smx_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(w_push), .i_entry(w_push_e), .i_pop(w_pop),
        .o_full(w_full), .o_empty(w_empty), .o_entry(w_pop_e)
    );

    smx_back u_back (
        .i_clk, .i_rst_n, .i_empty(w_empty), .i_entry(w_pop_e), .o_pop(w_pop),
        .o_m_tvalid, .i_m_tready, .o_m_tdata, .o_m_tlast, .o_m_tuser
    );
endmodule

// File: tb/softmax_row_unit_tb.sv
`timescale 1ns / 100ps

module softmax_row_unit_tb;
    import smx_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [15:0] score
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [15:0] probability
    logic        o_m_tlast;
    logic        o_m_tuser;   // [0] row_overflow

    softmax_row_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    typedef struct packed {
        logic [15:0] score;
        logic        row_end;
    } elem_t;

    typedef struct packed {
        logic [15:0] prob;
        logic        last;
        logic        ovf;
    } prob_t;

    // directed elements; chk=1 entries carry a typed-in probability
    typedef struct {
        elem_t       e;
        bit          chk;
        logic [15:0] prob;
    } dir_t;

    elem_t       stim_q[$];
    prob_t       prob_q[$];
    logic [15:0] hand_q[$];
    bit          hand_chk_q[$];

    logic signed [15:0] row_scores[ROW_LEN];
    logic signed [15:0] row_max;
    int                 row_cnt;
    bit                 row_ovf;

    int  errors;
    int  idle_cycles;
    bit  stim_done;
    bit  no_idle;
    int  total_items;

    const logic [16:0] pow2_lut[17] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549, 17'd55109, 17'd52773,
        17'd50535, 17'd48393, 17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219, 17'd32768
    };

    function automatic logic [16:0] exp_neg(input logic [15:0] m);
        logic [39:0] t;
        logic [15:0] n;
        logic [3:0]  k;
        logic [19:0] r;
        logic [16:0] hi, lo, p;
        logic [39:0] d;
        t = 40'(m) * 40'd94548;
        n = 16'(t >> 24);
        k = t[23:20];
        r = t[19:0];
        hi = pow2_lut[k];
        lo = pow2_lut[k + 1];
        d = (40'(hi - lo) * 40'(r) + 40'd524288) >> 20;
        p = hi - 17'(d);
        if (n == 0) return p;
        if (n >= 32) return 17'd0;
        return 17'((40'(p) + (40'd1 << (n - 1))) >> n);
    endfunction

    task automatic predict_softmax(input elem_t e);
        logic [39:0] sum;
        logic [39:0] ev, p;
        prob_t       r;
        if (row_cnt < ROW_LEN) begin
            row_scores[row_cnt] = e.score;
            row_cnt++;
            if ($signed(e.score) > row_max) row_max = e.score;
        end else begin
            row_ovf = 1'b1;
        end
        if (!e.row_end) return;
        sum = 0;
        for (int i = 0; i < row_cnt; i++)
            sum += 40'(exp_neg(16'(row_max - row_scores[i])));
        for (int i = 0; i < row_cnt; i++) begin
            ev = 40'(exp_neg(16'(row_max - row_scores[i])));
            p = 0;
            if (sum != 0) begin
                p = (ev * 40'd65536 + sum / 2) / sum;
                if (p > 40'd65535) p = 40'd65535;
            end
            r.prob = p[15:0];
            r.last = (i + 1 == row_cnt);
            r.ovf  = row_ovf;
            prob_q.push_back(r);
        end
        row_max = -16'sd32768;
        row_cnt = 0;
        row_ovf = 1'b0;
    endtask

    function automatic elem_t mk(input logic [15:0] s, input logic l);
        elem_t e;
        e.score = s;
        e.row_end = l;
        return e;
    endfunction

    function automatic logic [15:0] rand_score(input int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 2047)) - 16'd1024;
            default: return 16'($urandom_range(0, 255)) + 16'h0100;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // drive elements
    initial begin
        dir_t dir[$];
        int   len, mode, burst;
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tlast  = 1'b0;
        stim_done  = 1'b0;
        no_idle    = 1'b0;
        total_items = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single element row: probability saturates
        dir.push_back('{mk(16'h0000, 1), 1, 16'd65535});
        dir.push_back('{mk(16'h8000, 1), 1, 16'd65535});
        dir.push_back('{mk(16'h7FFF, 1), 1, 16'd65535});
        // two equal scores: half each, then another single element row
        dir.push_back('{mk(16'h1234, 0), 0, 0});
        dir.push_back('{mk(16'h1234, 1), 1, 16'd32768});
        dir.push_back('{mk(16'h1234, 1), 0, 0});
        // extreme spread: small one underflows to zero
        dir.push_back('{mk(16'h7FFF, 0), 1, 16'd65535});
        dir.push_back('{mk(16'h8000, 1), 1, 16'd0});
        dir.push_back('{mk(16'h8000, 0), 1, 16'd0});
        dir.push_back('{mk(16'h7FFF, 1), 1, 16'd65535});
        dir.push_back('{mk(16'hFFFF, 0), 0, 0});
        dir.push_back('{mk(16'h0100, 0), 0, 0});
        dir.push_back('{mk(16'h00FF, 0), 0, 0});
        dir.push_back('{mk(16'h5555, 0), 0, 0});
        dir.push_back('{mk(16'hAAAA, 1), 0, 0});
        foreach (dir[i]) begin
            stim_q.push_back(dir[i].e);
            if (dir[i].e.row_end) begin
                // hand values are typed per row's outputs in order
            end
        end
        foreach (dir[i]) begin
            if (i == 0 || i == 1 || i == 2 || i == 4 || i == 6 || i == 7 ||
                i == 8 || i == 9) begin
                hand_q.push_back(dir[i].prob);
                hand_chk_q.push_back(dir[i].chk);
            end else if (dir[i].e.row_end || i == 3 || (i >= 10 && i <= 14)) begin
                if (i == 3) begin
                    hand_q.push_back(16'd32768);
                    hand_chk_q.push_back(1'b1);
                end else begin
                    hand_q.push_back(16'd0);
                    hand_chk_q.push_back(1'b0);
                end
            end
        end
        // overflow rows: one of full length plus extras, row_end on a dropped element, then one of exactly full length
        for (int i = 0; i < ROW_LEN + 2; i++)
            stim_q.push_back(mk(rand_score(1), i == ROW_LEN + 1));
        for (int i = 0; i < ROW_LEN; i++)
            stim_q.push_back(mk(rand_score(0), i == ROW_LEN - 1));
        while (stim_q.size() < 400) begin
            mode = $urandom_range(0, 2);
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
                stim_q.push_back(mk(rand_score(mode), i == len - 1));
        end

        while (stim_q.size() > 0) begin
            if (!no_idle && stim_q.size() < 60) no_idle = 1'b1;
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                i_s_tvalid <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= stim_q[0].score;
            i_s_tlast  <= stim_q[0].row_end;
            @(posedge i_clk);
            while (!o_s_tready) @(posedge i_clk);
            predict_softmax(stim_q.pop_front());
            total_items++;
        end
        i_s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receive side
    initial begin
        prob_t exp_r;
        int    burst;
        logic [15:0] hv;
        bit    hc;
        errors = 0;
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (!no_idle && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 8);
                i_m_tready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) begin
                if (prob_q.size() == 0) begin
                    $display("%0t: unexpected transfer data=%h last=%b user=%b",
                             $time, o_m_tdata, o_m_tlast, o_m_tuser);
                    errors++;
                end else begin
                    exp_r = prob_q.pop_front();
                    if (hand_q.size() > 0) begin
                        hv = hand_q.pop_front();
                        hc = hand_chk_q.pop_front();
                        if (hc && hv != exp_r.prob) exp_r.prob = hv;
                    end
                    if (o_m_tdata !== exp_r.prob) begin
                        $display("%0t: probability expected %h actual %h",
                                 $time, exp_r.prob, o_m_tdata);
                        errors++;
                    end
                    if (o_m_tlast !== exp_r.last) begin
                        $display("%0t: tlast expected %b actual %b",
                                 $time, exp_r.last, o_m_tlast);
                        errors++;
                    end
                    if (o_m_tuser !== exp_r.ovf) begin
                        $display("%0t: row_overflow expected %b actual %b",
                                 $time, exp_r.ovf, o_m_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial begin
        row_max = -16'sd32768;
        row_cnt = 0;
        row_ovf = 1'b0;
        idle_cycles = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("softmax_row_unit verification failed");
                $finish;
            end
        end
    end

    initial begin
        wait (stim_done);
        while (prob_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && prob_q.size() == 0) begin
            $display("softmax_row_unit verification clean");
        end else begin
            $display("softmax_row_unit verification failed");
        end
        $finish;
    end
endmodule
